// ===== rtl/erd_pkg.sv =====
package erd_pkg;

  localparam int LIST_DEPTH_DEF    = 16;
  localparam int LOCATION_BITS_DEF = 4;
  localparam int TYPE_BITS_DEF     = 4;

  localparam int FIELD_W     = 8;
  localparam int CODE_W      = 2 * FIELD_W;
  localparam int CMD_W       = 2;
  localparam int LED_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int TICKS_W     = 16;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOT_ADD = 2'd3
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    scan_step;
    logic    add_write;
    logic    remove;
    logic    tick_count;
    logic    show_empty;
    logic    rot_read;
    logic    rot_write;
    logic    disp_read;
    logic    disp_set;
    logic    set_status;
    status_t status;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic count_zero;
    logic full;
    logic cd_next_zero;
    logic scan_match;
    logic scan_done;
  } dp_status_t;

endpackage

// ===== rtl/error_code_rotating_display_unit.sv =====
// Rotating error code display.
// Input channel (in_valid/in_stall) takes one command per transfer: add a
// (location, type) code, remove the front code, or tick the display timer.
// Each command yields exactly one result transfer on the output channel
// (out_valid/out_stall): the LED code and OK light held since the last tick,
// the add status and the stored entry count after the command.
// cfg_data sets the number of ticks between rotations; cfg_ready is always
// high, so a write completes whenever cfg_valid is high.
// A remove or the unused command goes from dispatch straight to the result.
// A tick shows an empty display or reads the front code for display, first
// rotating the front code when the countdown runs out, which takes a read
// and a write of the entry memory. An add runs the duplicate scan, reading
// one stored entry per cycle from the entry memory, then sets the add status.
// The next input is taken in the cycle after the result is loaded.
// Reset empties the list, clears the display and countdown and loads the
// rotation period with 1000. A stalled result holds in the output register;
// the next command is accepted meanwhile and its result waits until the
// held one is transferred.
module error_code_rotating_display_unit #(
  parameter int LIST_DEPTH    = erd_pkg::LIST_DEPTH_DEF,
  parameter int LOCATION_BITS = erd_pkg::LOCATION_BITS_DEF,
  parameter int TYPE_BITS     = erd_pkg::TYPE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [erd_pkg::CMD_W-1:0]       in_cmd,
  input  logic [erd_pkg::FIELD_W-1:0]     in_location,
  input  logic [erd_pkg::FIELD_W-1:0]     in_error_type,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [erd_pkg::LED_W-1:0]       out_led_bits,
  output logic                            out_ok_light,
  output logic [erd_pkg::STATUS_W-1:0]    out_add_status,
  output logic [erd_pkg::COUNT_OUT_W-1:0] out_entry_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [erd_pkg::TICKS_W-1:0]     cfg_data
);
  import erd_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t dp_sts;

  assign cfg_ready = 1'b1;

  erd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .ctl       (ctl)
  );

  erd_dpath #(
    .LIST_DEPTH    (LIST_DEPTH),
    .LOCATION_BITS (LOCATION_BITS),
    .TYPE_BITS     (TYPE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (dp_sts),
    .in_cmd          (in_cmd),
    .in_location     (in_location),
    .in_error_type   (in_error_type),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_led_bits    (out_led_bits),
    .out_ok_light    (out_ok_light),
    .out_add_status  (out_add_status),
    .out_entry_count (out_entry_count)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is still in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> !(out_valid && out_stall))
    else $error("stalled result overwritten");

  a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.add_write |-> !dp_sts.full)
    else $error("entry appended to a full list");

  a_rotate_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rot_write |-> !dp_sts.count_zero)
    else $error("rotation with an empty list");

endmodule

// ===== rtl/erd_dpath.sv =====
module erd_dpath #(
  parameter int LIST_DEPTH    = erd_pkg::LIST_DEPTH_DEF,
  parameter int LOCATION_BITS = erd_pkg::LOCATION_BITS_DEF,
  parameter int TYPE_BITS     = erd_pkg::TYPE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  erd_pkg::ctrl_cmd_t              ctl,
  output erd_pkg::dp_status_t             sts,
  input  logic [erd_pkg::CMD_W-1:0]       in_cmd,
  input  logic [erd_pkg::FIELD_W-1:0]     in_location,
  input  logic [erd_pkg::FIELD_W-1:0]     in_error_type,
  input  logic                            cfg_we,
  input  logic [erd_pkg::TICKS_W-1:0]     cfg_data,
  output logic [erd_pkg::LED_W-1:0]       out_led_bits,
  output logic                            out_ok_light,
  output logic [erd_pkg::STATUS_W-1:0]    out_add_status,
  output logic [erd_pkg::COUNT_OUT_W-1:0] out_entry_count
);
  import erd_pkg::*;

  localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int COUNT_W = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W   = COUNT_W + 1;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [COUNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(LIST_DEPTH)) sum = sum - SUM_W'(LIST_DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  logic [CODE_W-1:0]  mem [LIST_DEPTH];
  logic [CODE_W-1:0]  rdata_r;
  logic [IDX_W-1:0]   head_r;
  logic [COUNT_W-1:0] count_r;
  logic [TICKS_W-1:0] cd_r;
  logic [TICKS_W-1:0] ticks_r;
  logic [LED_W-1:0]   shown_bits_r;
  logic               shown_ok_r;
  logic               pend_r;
  cmd_t               cmd_r;
  logic [CODE_W-1:0]  code_r;
  logic [COUNT_W-1:0] scan_k_r;
  status_t            status_r;
  logic [LED_W-1:0]   out_bits_r;
  logic               out_ok_r;
  status_t            out_status_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               scan_live;
  logic               rd_en;
  logic [IDX_W-1:0]   raddr;
  logic               wr_en;
  logic [IDX_W-1:0]   waddr;
  logic [CODE_W-1:0]  wdata;
  logic [IDX_W-1:0]   head_next1;
  logic [FIELD_W-1:0] disp_loc;
  logic [FIELD_W-1:0] disp_typ;
  logic               disp_ok;
  logic [CODE_W-1:0]  disp_wide;
  logic [LED_W-1:0]   disp_bits;

  assign scan_live  = scan_k_r != count_r;
  assign rd_en      = ctl.rot_read || ctl.disp_read || (ctl.scan_step && scan_live);
  assign raddr      = ctl.scan_step ? slot(head_r, scan_k_r) : head_r;
  assign wr_en      = ctl.add_write || ctl.rot_write;
  assign waddr      = slot(head_r, count_r);
  assign wdata      = ctl.rot_write ? rdata_r : code_r;
  assign head_next1 = slot(head_r, COUNT_W'(1));

  assign disp_loc  = rdata_r[CODE_W-1:FIELD_W];
  assign disp_typ  = rdata_r[FIELD_W-1:0];
  assign disp_ok   = ((disp_loc >> LOCATION_BITS) == '0) && ((disp_typ >> TYPE_BITS) == '0);
  assign disp_wide = (CODE_W'(disp_loc) << TYPE_BITS) | CODE_W'(disp_typ);
  assign disp_bits = disp_ok ? disp_wide[LED_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      count_r      <= '0;
      cd_r         <= '0;
      ticks_r      <= TICKS_RESET;
      shown_bits_r <= '0;
      shown_ok_r   <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      if (cfg_we) ticks_r <= cfg_data;
      if (ctl.capture) begin
        pend_r <= 1'b0;
      end else if (ctl.scan_step) begin
        pend_r <= scan_live;
      end
      if (ctl.add_write) count_r <= count_r + COUNT_W'(1);
      if (ctl.remove && count_r != '0) begin
        head_r  <= head_next1;
        count_r <= count_r - COUNT_W'(1);
      end
      if (ctl.tick_count && cd_r != '0) cd_r <= cd_r - TICKS_W'(1);
      if (ctl.rot_write) begin
        head_r <= head_next1;
        cd_r   <= ticks_r;
      end
      if (ctl.show_empty) begin
        shown_bits_r <= '0;
        shown_ok_r   <= 1'b1;
      end
      if (ctl.disp_set) begin
        shown_bits_r <= disp_bits;
        shown_ok_r   <= disp_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= cmd_t'(in_cmd);
      code_r   <= {in_location, in_error_type};
      scan_k_r <= '0;
    end else if (ctl.scan_step && scan_live) begin
      scan_k_r <= scan_k_r + COUNT_W'(1);
    end
    if (ctl.set_status) status_r <= ctl.status;
    if (ctl.load_out) begin
      out_bits_r   <= shown_bits_r;
      out_ok_r     <= shown_ok_r;
      out_status_r <= status_r;
      out_count_r  <= count_r;
    end
  end

  assign sts.cmd          = cmd_r;
  assign sts.count_zero   = count_r == '0;
  assign sts.full         = count_r == COUNT_W'(LIST_DEPTH);
  assign sts.cd_next_zero = cd_r <= TICKS_W'(1);
  assign sts.scan_match   = pend_r && (rdata_r == code_r);
  assign sts.scan_done    = !pend_r && !scan_live;

  assign out_led_bits    = out_bits_r;
  assign out_ok_light    = out_ok_r;
  assign out_add_status  = out_status_r;
  assign out_entry_count = COUNT_OUT_W'(out_count_r);

endmodule

// ===== rtl/erd_ctrl.sv =====
module erd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  erd_pkg::dp_status_t sts,
  output erd_pkg::ctrl_cmd_t  ctl
);
  import erd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_ADD,
    S_ROT_RD,
    S_ROT_WR,
    S_DISP_RD,
    S_DISP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        ctl.set_status = 1'b1;
        ctl.status     = ST_NOT_ADD;
        unique case (sts.cmd)
          CMD_ADD: begin
            ctl.set_status = 1'b0;
            state_nxt      = S_SCAN;
          end
          CMD_REMOVE: begin
            ctl.remove = 1'b1;
            state_nxt  = S_DONE;
          end
          CMD_TICK: begin
            ctl.tick_count = 1'b1;
            if (sts.count_zero) begin
              ctl.show_empty = 1'b1;
              state_nxt      = S_DONE;
            end else if (sts.cd_next_zero) begin
              state_nxt = S_ROT_RD;
            end else begin
              state_nxt = S_DISP_RD;
            end
          end
          CMD_RSVD: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_match) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_DUP;
          state_nxt      = S_DONE;
        end else if (sts.scan_done) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        ctl.set_status = 1'b1;
        if (sts.full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.status    = ST_ADDED;
          ctl.add_write = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_ROT_RD: begin
        ctl.rot_read = 1'b1;
        state_nxt    = S_ROT_WR;
      end
      S_ROT_WR: begin
        ctl.rot_write = 1'b1;
        state_nxt     = S_DISP_RD;
      end
      S_DISP_RD: begin
        ctl.disp_read = 1'b1;
        state_nxt     = S_DISP;
      end
      S_DISP: begin
        ctl.disp_set = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule
